// File: design/spce_pkg.sv
// ----------------------------------------------------------------------------
// spce_pkg
// Shared types and constants for the shortest path cost engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spce_pkg;

    // input word commands
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_SOLVE = 2'd2
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_FOUND   = 2'd0,
        STAT_UNREACH = 2'd1,
        STAT_INVALID = 2'd2
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_SETTLE,
        S_RELAX,
        S_DONE
    } state_t;

    localparam int          NODE_ID_W      = 6;
    localparam int          COST_W         = 24;
    localparam int          NODE_CNT_W     = 7;
    localparam logic [23:0] COST_MAX       = 24'hFF_FFFF;
    localparam logic [6:0]  NODE_CNT_RESET = 7'd64;

endpackage

`default_nettype wire

// File: design/spce_ram.sv
// ----------------------------------------------------------------------------
// spce_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: design/shortest_path_cost_engine_top.sv
// ----------------------------------------------------------------------------
// shortest_path_cost_engine_top
// Dijkstra shortest path cost over an edge table held in RAM.
// ----------------------------------------------------------------------------
// Clear and add edge words are taken one per cycle, back to back, with no result.
// Solve: a node check, node RAM init, then up to n-1 rounds of
//   scan + settle + relax, a last scan, then into the output register;
//   invalid nodes skip init, scan and relax.
// The node RAM read-modify-write loop sets the rate; input stalls during a solve.
// rst_n is asynchronous: edge count, drop flag and node_count reset;
//   node RAM needs no clearing since each solve rewrites it.
`timescale 1ns / 1ps
`default_nettype none

module shortest_path_cost_engine_top #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [5:0]  from_node,
    input  wire logic [5:0]  to_node,
    input  wire logic [15:0] edge_weight,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [23:0]      path_cost,
    output logic [1:0]       status,
    output logic             edges_dropped
);

    import spce_pkg::*;

    localparam int NAW    = $clog2(MAX_NODES);
    localparam int NCW    = $clog2(MAX_NODES + 1);
    localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW    = $clog2(MAX_EDGES + 1);
    localparam int DIST_W = WEIGHT_BITS + $clog2(MAX_NODES);
    localparam int NW     = DIST_W + 2;
    localparam int EW     = 2 * NODE_ID_W + WEIGHT_BITS;
    localparam int WIDE   = (DIST_W > COST_W) ? DIST_W : COST_W;

    state_t             state_reg,      state_next;
    logic [6:0]         node_count_reg, node_count_next;
    logic [ETW-1:0]     edge_total_reg, edge_total_next;
    logic               drop_flag_reg,  drop_flag_next;
    logic [NCW-1:0]     n_reg,          n_next;
    logic [NAW-1:0]     start_reg,      start_next;
    logic [NAW-1:0]     goal_reg,       goal_next;
    logic [NCW-1:0]     idx_reg,        idx_next;
    logic               scan_vld_reg,   scan_vld_next;
    logic [NAW-1:0]     scan_addr_reg,  scan_addr_next;
    logic [DIST_W-1:0]  least_reg,      least_next;
    logic               found_reg,      found_next;
    logic [NAW-1:0]     pick_reg,       pick_next;
    logic [ETW-1:0]     e_reg,          e_next;
    logic               a_vld_reg,      a_vld_next;
    logic               b_vld_reg,      b_vld_next;
    logic [NAW-1:0]     b_dst_reg,      b_dst_next;
    logic [WEIGHT_BITS-1:0] b_w_reg,    b_w_next;
    logic               fwd_vld_reg,    fwd_vld_next;
    logic [NAW-1:0]     fwd_addr_reg,   fwd_addr_next;
    logic [NW-1:0]      fwd_word_reg,   fwd_word_next;
    logic [23:0]        res_cost_reg,   res_cost_next;
    status_t            res_status_reg, res_status_next;
    logic               out_valid_reg,  out_valid_next;
    logic [23:0]        out_cost_reg,   out_cost_next;
    status_t            out_status_reg, out_status_next;
    logic               out_drop_reg,   out_drop_next;

    logic               in_accept;
    logic [NCW-1:0]     n_cur;
    logic [31:0]        w_ext;

    logic               edge_we;
    logic [EAW-1:0]     edge_waddr;
    logic [EW-1:0]      edge_wdata;
    logic [EAW-1:0]     edge_raddr;
    logic [EW-1:0]      edge_rd;
    logic [5:0]         e_src;
    logic [5:0]         e_dst;
    logic [WEIGHT_BITS-1:0] e_w;

    logic               node_we;
    logic [NAW-1:0]     node_waddr;
    logic [NW-1:0]      node_wdata;
    logic [NAW-1:0]     node_raddr;
    logic [NW-1:0]      node_rd;
    logic [NW-1:0]      node_c;

    logic               s_better;
    logic [DIST_W-1:0]  s_least;
    logic               s_found;
    logic [NAW-1:0]     s_pick;
    logic [WIDE-1:0]    sat_w;
    logic [23:0]        sat_cost;
    logic [DIST_W:0]    cand;
    logic               improve;

    // handshake and node count clamp
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign n_cur     = (32'(node_count_reg) > MAX_NODES) ? NCW'(MAX_NODES)
                                                         : NCW'(node_count_reg);
    assign w_ext     = 32'(edge_weight);

    // edge table RAM
    assign edge_we    = in_accept && (cmd == CMD_ADD) && (32'(edge_total_reg) < MAX_EDGES);
    assign edge_waddr = EAW'(edge_total_reg);
    assign edge_wdata = {from_node, to_node, w_ext[WEIGHT_BITS-1:0]};
    assign edge_raddr = EAW'(e_reg);
    assign e_src      = edge_rd[EW-1 -: NODE_ID_W];
    assign e_dst      = edge_rd[WEIGHT_BITS + NODE_ID_W - 1 -: NODE_ID_W];
    assign e_w        = edge_rd[WEIGHT_BITS-1:0];

    spce_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EDGES),
        .AW    (EAW)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (edge_we),
        .wr_addr (edge_waddr),
        .wr_data (edge_wdata),
        .rd_addr (edge_raddr),
        .rd_data (edge_rd)
    );

    // node RAM: {settled, finite, distance}
    spce_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_NODES),
        .AW    (NAW)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (node_we),
        .wr_addr (node_waddr),
        .wr_data (node_wdata),
        .rd_addr (node_raddr),
        .rd_data (node_rd)
    );

    // scan compare, lowest index wins a tie
    assign s_better = scan_vld_reg && !node_rd[NW-1] && node_rd[NW-2]
                      && (!found_reg || (node_rd[DIST_W-1:0] < least_reg));
    assign s_least  = s_better ? node_rd[DIST_W-1:0] : least_reg;
    assign s_found  = found_reg || s_better;
    assign s_pick   = s_better ? scan_addr_reg : pick_reg;
    assign sat_w    = WIDE'(s_least);
    assign sat_cost = (sat_w > WIDE'(COST_MAX)) ? COST_MAX : sat_w[23:0];

    // relax compare with forwarding of the previous cycle's write
    assign node_c  = (fwd_vld_reg && (fwd_addr_reg == b_dst_reg)) ? fwd_word_reg : node_rd;
    assign cand    = {1'b0, least_reg} + (DIST_W+1)'(b_w_reg);
    assign improve = b_vld_reg && !node_c[NW-1]
                     && (!node_c[NW-2] || (cand < {1'b0, node_c[DIST_W-1:0]}));

    // next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        edge_total_next = edge_total_reg;
        drop_flag_next  = drop_flag_reg;
        n_next          = n_reg;
        start_next      = start_reg;
        goal_next       = goal_reg;
        idx_next        = idx_reg;
        scan_vld_next   = scan_vld_reg;
        scan_addr_next  = scan_addr_reg;
        least_next      = least_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        e_next          = e_reg;
        a_vld_next      = a_vld_reg;
        b_vld_next      = b_vld_reg;
        b_dst_next      = b_dst_reg;
        b_w_next        = b_w_reg;
        fwd_vld_next    = fwd_vld_reg;
        fwd_addr_next   = fwd_addr_reg;
        fwd_word_next   = fwd_word_reg;
        res_cost_next   = res_cost_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_cost_next   = out_cost_reg;
        out_status_next = out_status_reg;
        out_drop_next   = out_drop_reg;
        node_we         = 1'b0;
        node_waddr      = '0;
        node_wdata      = '0;
        node_raddr      = '0;

        if (cfg_wr_en)
        begin
            node_count_next = cfg_wr_data;
        end

        // output word taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (cmd)
                        CMD_CLEAR:
                        begin
                            edge_total_next = '0;
                            drop_flag_next  = 1'b0;
                        end
                        CMD_ADD:
                        begin
                            if (32'(edge_total_reg) < MAX_EDGES)
                            begin
                                edge_total_next = edge_total_reg + 1'b1;
                            end
                            else
                            begin
                                drop_flag_next = 1'b1;
                            end
                        end
                        CMD_SOLVE:
                        begin
                            n_next     = n_cur;
                            start_next = NAW'(from_node);
                            goal_next  = NAW'(to_node);
                            idx_next   = '0;
                            if ((32'(from_node) >= 32'(n_cur)) || (32'(to_node) >= 32'(n_cur)))
                            begin
                                res_status_next = STAT_INVALID;
                                res_cost_next   = '0;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_INIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // write every node in use: start finite at zero, rest infinite
            S_INIT:
            begin
                node_we    = 1'b1;
                node_waddr = NAW'(idx_reg);
                node_wdata = {1'b0, (NAW'(idx_reg) == start_reg), DIST_W'(0)};
                if (idx_reg == n_reg - 1'b1)
                begin
                    idx_next      = '0;
                    scan_vld_next = 1'b0;
                    found_next    = 1'b0;
                    state_next    = S_SCAN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // stream nodes for the least unsettled finite distance
            S_SCAN:
            begin
                node_raddr = NAW'(idx_reg);
                least_next = s_least;
                found_next = s_found;
                pick_next  = s_pick;
                if (idx_reg < n_reg)
                begin
                    idx_next       = idx_reg + 1'b1;
                    scan_vld_next  = 1'b1;
                    scan_addr_next = NAW'(idx_reg);
                end
                else
                begin
                    scan_vld_next = 1'b0;
                    if (!s_found)
                    begin
                        res_status_next = STAT_UNREACH;
                        res_cost_next   = '0;
                        state_next      = S_DONE;
                    end
                    else if (s_pick == goal_reg)
                    begin
                        res_status_next = STAT_FOUND;
                        res_cost_next   = sat_cost;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SETTLE;
                    end
                end
            end

            // mark the picked node settled
            S_SETTLE:
            begin
                node_we      = 1'b1;
                node_waddr   = pick_reg;
                node_wdata   = {1'b1, 1'b1, least_reg};
                e_next       = '0;
                a_vld_next   = 1'b0;
                b_vld_next   = 1'b0;
                fwd_vld_next = 1'b0;
                state_next   = S_RELAX;
            end

            // three stage pipe: edge read, node read, compare and write back
            S_RELAX:
            begin
                if (e_reg < edge_total_reg)
                begin
                    a_vld_next = 1'b1;
                    e_next     = e_reg + 1'b1;
                end
                else
                begin
                    a_vld_next = 1'b0;
                end

                node_raddr = NAW'(e_dst);
                b_vld_next = a_vld_reg && (32'(e_src) == 32'(pick_reg))
                             && (32'(e_dst) < 32'(n_reg));
                b_dst_next = NAW'(e_dst);
                b_w_next   = e_w;

                if (improve)
                begin
                    node_we       = 1'b1;
                    node_waddr    = b_dst_reg;
                    node_wdata    = {1'b0, 1'b1, cand[DIST_W-1:0]};
                    fwd_vld_next  = 1'b1;
                    fwd_addr_next = b_dst_reg;
                    fwd_word_next = {1'b0, 1'b1, cand[DIST_W-1:0]};
                end
                else
                begin
                    fwd_vld_next = 1'b0;
                end

                if ((e_reg == edge_total_reg) && !a_vld_reg && !b_vld_reg)
                begin
                    idx_next      = '0;
                    scan_vld_next = 1'b0;
                    found_next    = 1'b0;
                    state_next    = S_SCAN;
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_cost_next   = res_cost_reg;
                    out_status_next = res_status_reg;
                    out_drop_next   = drop_flag_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_CNT_RESET;
            edge_total_reg <= '0;
            drop_flag_reg  <= 1'b0;
            scan_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
            fwd_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            edge_total_reg <= edge_total_next;
            drop_flag_reg  <= drop_flag_next;
            scan_vld_reg   <= scan_vld_next;
            found_reg      <= found_next;
            a_vld_reg      <= a_vld_next;
            b_vld_reg      <= b_vld_next;
            fwd_vld_reg    <= fwd_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        start_reg      <= start_next;
        goal_reg       <= goal_next;
        idx_reg        <= idx_next;
        scan_addr_reg  <= scan_addr_next;
        least_reg      <= least_next;
        pick_reg       <= pick_next;
        e_reg          <= e_next;
        b_dst_reg      <= b_dst_next;
        b_w_reg        <= b_w_next;
        fwd_addr_reg   <= fwd_addr_next;
        fwd_word_reg   <= fwd_word_next;
        res_cost_reg   <= res_cost_next;
        res_status_reg <= res_status_next;
        out_cost_reg   <= out_cost_next;
        out_status_reg <= out_status_next;
        out_drop_reg   <= out_drop_next;
    end

    assign out_valid     = out_valid_reg;
    assign path_cost     = out_cost_reg;
    assign status        = out_status_reg;
    assign edges_dropped = out_drop_reg;

endmodule

`default_nettype wire

// File: design/spce_checker.sv
// ----------------------------------------------------------------------------
// spce_checker
// Port level checks for the shortest path cost engine, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spce_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  cmd,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [23:0] path_cost,
    input wire logic [1:0]  status
);

    import spce_pkg::*;

    // stalled result word stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // stalled result payload holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(path_cost) && $stable(status))
        else $error("result payload changed while stalled");

    // only a found result carries a cost
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_FOUND) |-> (path_cost == 24'd0))
        else $error("nonzero cost without a found status");

    // an accepted solve holds off the next input word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_SOLVE) |=> in_stall)
        else $error("input taken right after a solve");

endmodule

bind shortest_path_cost_engine_top spce_checker u_spce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .path_cost (path_cost),
    .status    (status)
);

`default_nettype wire

// File: dv/shortest_path_cost_engine_top_tb.sv
// ----------------------------------------------------------------------------
// shortest_path_cost_engine_top_tb
// Loads edge tables and solves shortest path costs. Each result word is
// compared with a predictor that runs a least-distance search in the bench.
// A directed table comes first, then random graphs with random idle gaps on
// both channels and node_count changes between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shortest_path_cost_engine_top_tb;
    import spce_pkg::*;

    localparam int NODES     = 64;
    localparam int EDGES     = 256;
    localparam int IDLE_MAX  = 18;
    localparam int WDOG_MAX  = 200000;
    localparam int RAND_ITEMS = 2000;

    // one result word
    typedef struct packed {
        logic [23:0] cost;
        status_t     stat;
        logic        dropped;
    } answer_t;

    // one directed stimulus row; has_exp marks an answer typed in by hand
    typedef struct {
        logic [1:0]  op;
        logic [5:0]  src;
        logic [5:0]  dst;
        logic [15:0] wt;
        logic        has_exp;
        answer_t     exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [5:0]  from_node;
    logic [5:0]  to_node;
    logic [15:0] edge_weight;
    logic        out_valid;
    logic        out_stall;
    logic [23:0] path_cost;
    logic [1:0]  status;
    logic        edges_dropped;

    shortest_path_cost_engine_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .from_node    (from_node),
        .to_node      (to_node),
        .edge_weight  (edge_weight),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .path_cost    (path_cost),
        .status       (status),
        .edges_dropped(edges_dropped)
    );

    // predictor state
    logic [5:0]  tbl_src [EDGES];
    logic [5:0]  tbl_dst [EDGES];
    logic [15:0] tbl_wt  [EDGES];
    int          tbl_count;
    logic        tbl_dropped;
    logic [6:0]  nodes_cfg;

    answer_t answer_queue[$];
    int      errors;
    int      idle_cycles;
    bit      rx_done;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // least-distance search over the bench copy of the edge table
    function automatic answer_t solve_cost(logic [5:0] start, logic [5:0] goal);
        longint unsigned dist_to [NODES];
        bit              done [NODES];
        int              n;
        int              pick;
        longint unsigned least;
        answer_t         a;
        n = (nodes_cfg > 7'(NODES)) ? NODES : int'(nodes_cfg);
        a.cost = '0;
        a.dropped = tbl_dropped;
        if (start >= n || goal >= n)
        begin
            a.stat = STAT_INVALID;
            return a;
        end
        for (int i = 0; i < NODES; i++)
        begin
            dist_to[i] = '1;
            done[i] = 1'b0;
        end
        dist_to[start] = 0;
        forever
        begin
            pick = n;
            least = '1;
            for (int i = 0; i < n; i++)
                if (!done[i] && dist_to[i] < least)
                begin
                    least = dist_to[i];
                    pick = i;
                end
            if (pick >= n)
            begin
                a.stat = STAT_UNREACH;
                return a;
            end
            if (pick == goal)
            begin
                a.stat = STAT_FOUND;
                a.cost = (least > COST_MAX) ? COST_MAX : least[23:0];
                return a;
            end
            done[pick] = 1'b1;
            for (int e = 0; e < tbl_count; e++)
                if (tbl_src[e] == pick && tbl_dst[e] < n && !done[tbl_dst[e]])
                    if (least + tbl_wt[e] < dist_to[tbl_dst[e]])
                        dist_to[tbl_dst[e]] = least + tbl_wt[e];
        end
    endfunction

    // update the predictor for an accepted word; returns 1 with a result
    function automatic bit apply_word(logic [1:0] op, logic [5:0] a, logic [5:0] b,
                                      logic [15:0] w, output answer_t ans);
        ans = '0;
        case (op)
            CMD_CLEAR:
            begin
                tbl_count = 0;
                tbl_dropped = 1'b0;
            end
            CMD_ADD:
            begin
                if (tbl_count < EDGES)
                begin
                    tbl_src[tbl_count] = a;
                    tbl_dst[tbl_count] = b;
                    tbl_wt[tbl_count] = w;
                    tbl_count++;
                end
                else
                    tbl_dropped = 1'b1;
            end
            CMD_SOLVE:
            begin
                ans = solve_cost(a, b);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // send one word, wait for acceptance, queue its expected result
    task automatic send_word(logic [1:0] op, logic [5:0] a, logic [5:0] b,
                             logic [15:0] w, logic has_exp, answer_t fixed);
        int      gap;
        answer_t ans;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        from_node   <= a;
        to_node     <= b;
        edge_weight <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (apply_word(op, a, b, w, ans))
            answer_queue = {answer_queue, (has_exp ? fixed : ans)};
    endtask

    // write node_count once all results are in and the engine has settled
    task automatic set_nodes(logic [6:0] value);
        in_valid <= 1'b0;
        while (answer_queue.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        nodes_cfg = value;
    endtask

    // random phase: mostly in-range edge adds and solves, some out-of-range ones
    task automatic random_phase(int count);
        int          n;
        int          kind;
        logic [15:0] w;
        answer_t     none;
        none = '0;
        n = (nodes_cfg == 0) ? 1 : ((nodes_cfg > 7'(NODES)) ? NODES : int'(nodes_cfg));
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: w = 16'hFFFF;
                1: w = 16'($urandom_range(0, 15));
                default: w = 16'($urandom);
            endcase
            if (kind < 2)
                send_word(CMD_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom), 1'b0, none);
            else if (kind < 3)
                send_word(2'd3, 6'($urandom), 6'($urandom), 16'($urandom), 1'b0, none);
            else if (kind < 62)
                send_word(CMD_ADD, 6'($urandom_range(0, n - 1)),
                          6'(($urandom_range(0, 9) == 0) ? $urandom
                                                         : $urandom_range(0, n - 1)),
                          w, 1'b0, none);
            else if (kind < 70)
                send_word(CMD_ADD, 6'($urandom), 6'($urandom), w, 1'b0, none);
            else if (kind < 95)
                send_word(CMD_SOLVE, 6'($urandom_range(0, n - 1)),
                          6'($urandom_range(0, n - 1)), 16'($urandom), 1'b0, none);
            else
                send_word(CMD_SOLVE, 6'($urandom), 6'($urandom), 16'($urandom), 1'b0, none);
        end
    endtask

    // result checker and output stall
    initial
    begin
        answer_t want;
        int      hold;
        out_stall = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (answer_queue.size() == 0)
                begin
                    $display("%0t: unexpected result cost=%0d status=%0d dropped=%0b",
                             $time, path_cost, status, edges_dropped);
                    errors++;
                end
                else
                begin
                    want = answer_queue.pop_front();
                    if (path_cost !== want.cost)
                    begin
                        $display("%0t: path_cost expected %0d actual %0d",
                                 $time, want.cost, path_cost);
                        errors++;
                    end
                    if (status !== want.stat)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.stat, status);
                        errors++;
                    end
                    if (edges_dropped !== want.dropped)
                    begin
                        $display("%0t: edges_dropped expected %0b actual %0b",
                                 $time, want.dropped, edges_dropped);
                        errors++;
                    end
                end
                hold = rx_done ? 0 :
                       (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX));
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no accepted word
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("shortest_path_cost_engine_top test failed");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        row_t    rows [13];
        answer_t none;
        none = '0;
        errors = 0;
        rx_done = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        cmd = CMD_CLEAR;
        from_node = '0;
        to_node = '0;
        edge_weight = '0;
        tbl_count = 0;
        tbl_dropped = 1'b0;
        nodes_cfg = NODE_CNT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        rows[0]  = '{CMD_SOLVE, 6'd5, 6'd5, 16'd0, 1'b1, '{24'd0, STAT_FOUND, 1'b0}};
        rows[1]  = '{CMD_SOLVE, 6'd0, 6'd63, 16'd0, 1'b1, '{24'd0, STAT_UNREACH, 1'b0}};
        rows[2]  = '{CMD_ADD, 6'd0, 6'd1, 16'hFFFF, 1'b0, none};
        rows[3]  = '{CMD_ADD, 6'd1, 6'd63, 16'hFFFF, 1'b0, none};
        rows[4]  = '{CMD_ADD, 6'd0, 6'd63, 16'd0, 1'b0, none};
        rows[5]  = '{CMD_ADD, 6'd63, 6'd2, 16'd7, 1'b0, none};
        rows[6]  = '{CMD_SOLVE, 6'd0, 6'd63, 16'd0, 1'b1, '{24'd0, STAT_FOUND, 1'b0}};
        rows[7]  = '{CMD_SOLVE, 6'd0, 6'd2, 16'd0, 1'b0, none};
        rows[8]  = '{CMD_SOLVE, 6'd63, 6'd0, 16'd0, 1'b0, none};
        rows[9]  = '{CMD_SOLVE, 6'd1, 6'd2, 16'hFFFF, 1'b0, none};
        rows[10] = '{2'd3, 6'd63, 6'd63, 16'hFFFF, 1'b0, none};
        rows[11] = '{CMD_CLEAR, 6'd0, 6'd0, 16'd0, 1'b0, none};
        rows[12] = '{CMD_SOLVE, 6'd0, 6'd63, 16'd0, 1'b1, '{24'd0, STAT_UNREACH, 1'b0}};
        foreach (rows[i])
            send_word(rows[i].op, rows[i].src, rows[i].dst, rows[i].wt,
                      rows[i].has_exp, rows[i].exp);

        // long chain of heavy edges: deep search, then overfill the table
        for (int i = 0; i < 63; i++)
            send_word(CMD_ADD, 6'(i), 6'(i + 1), 16'hFFFF, 1'b0, none);
        for (int i = 0; i < 63; i++)
            send_word(CMD_ADD, 6'(i + 1), 6'(i), 16'hFFFF, 1'b0, none);
        send_word(CMD_SOLVE, 6'd0, 6'd63, 16'd0, 1'b0, none);
        for (int i = 0; i < 132; i++)
            send_word(CMD_ADD, 6'($urandom), 6'($urandom), 16'($urandom), 1'b0, none);
        send_word(CMD_SOLVE, 6'd63, 6'd0, 16'd0, 1'b0, none);
        send_word(CMD_CLEAR, 6'd0, 6'd0, 16'd0, 1'b0, none);

        // node_count extremes and invalid nodes
        set_nodes(7'd1);
        send_word(CMD_SOLVE, 6'd0, 6'd0, 16'd0, 1'b1, '{24'd0, STAT_FOUND, 1'b0});
        send_word(CMD_SOLVE, 6'd0, 6'd1, 16'd0, 1'b1, '{24'd0, STAT_INVALID, 1'b0});
        set_nodes(7'd0);
        send_word(CMD_SOLVE, 6'd0, 6'd0, 16'd0, 1'b1, '{24'd0, STAT_INVALID, 1'b0});
        set_nodes(7'd127);
        send_word(CMD_SOLVE, 6'd63, 6'd63, 16'd0, 1'b1, '{24'd0, STAT_FOUND, 1'b0});

        // random phases with different node counts
        set_nodes(7'd8);
        random_phase(RAND_ITEMS / 4);
        set_nodes(7'd2);
        random_phase(RAND_ITEMS / 8);
        set_nodes(7'd20);
        random_phase(RAND_ITEMS / 4);
        set_nodes(7'd64);
        send_word(CMD_CLEAR, 6'd0, 6'd0, 16'd0, 1'b0, none);
        random_phase(RAND_ITEMS / 8);
        set_nodes(7'($urandom_range(3, 12)));
        random_phase(RAND_ITEMS / 4);

        // drain
        in_valid <= 1'b0;
        rx_done = 1;
        while (answer_queue.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("shortest_path_cost_engine_top test passed");
        else
            $display("shortest_path_cost_engine_top test failed");
        $finish;
    end

endmodule
